>>> rtl/core/xscp_pkg.sv
// Shared types and constants for the XOR string cipher with a minimal-standard key generator.
// Holds the word types, the register indexes, the control state type and the key byte fold.
// No dependencies.
package xscp_pkg;

   localparam int MAX_KEY_BYTES_DEF = 128;

   localparam logic [14:0] PM_MULT      = 15'd16807;
   localparam logic [31:0] PM_MOD       = 32'h7FFF_FFFF;
   localparam logic [31:0] GEN_RESET    = 32'h5DEE_CE6D;
   localparam logic [31:0] SEED_RESET   = 32'd1575931501;
   localparam logic [7:0]  LENGTH_RESET = 8'd128;
   localparam logic [6:0]  KEY_MOD      = 7'h7F;
   localparam logic [7:0]  KEY_TOP_BIT  = 8'h80;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_SEED   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 1'd1;

   localparam logic REQ_GEN_KEY  = 1'b0;
   localparam logic REQ_STR_BYTE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic        encrypt;
      logic [31:0] string_address;
      logic [7:0]  data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_string;
      logic       key_ready;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OUT,
      ST_DIV,
      ST_XOR,
      ST_GEN_MUL,
      ST_GEN_ADD,
      ST_GEN_WR
   } state_type;

   // Since 128 is 1 mod 127, folding 7-bit digits keeps the value mod 127.
   function automatic logic [7:0] key_byte_of(input logic [31:0] x);
      logic [9:0] s1;
      logic [7:0] s2;
      logic [7:0] m;
      s1 = 10'(x[6:0]) + 10'(x[13:7]) + 10'(x[20:14]) + 10'(x[27:21]) + 10'(x[31:28]);
      s2 = 8'(s1[6:0]) + 8'(s1[9:7]);
      if (s2 >= {1'b0, KEY_MOD}) begin
         m = s2 - {1'b0, KEY_MOD};
      end else begin
         m = s2;
      end
      return m | KEY_TOP_BIT;
   endfunction

endpackage

>>> rtl/core/xor_string_cipher_prng_key_top.sv
// Top level of the XOR string cipher: key table memory, key generator, index divider and control.
// Depends on xscp_pkg.
//
// Usage:
//   req_* carries one word per request: either a key-generation command or one string byte.
//   rsp_* returns exactly one word per request, in request order.
//   csr_* writes key_seed (index 0) or key_length (index 1); write only while the block is idle.
// Request handling:
//   A copied byte or a terminator goes straight to the output state; a new word is taken every
//   cycle while the output register is free. An XORed byte goes through the XOR state first,
//   which uses the registered read of the key memory. For the first XORed byte of a string,
//   the start address is reduced modulo the key length by a one-bit-per-cycle remainder unit
//   (32 steps); it also runs when a shortened key length leaves the index past the key end.
//   Key generation writes L key bytes, where L is the key length with 0 taken as 1 and values
//   above the table size taken as the table size: each key byte needs a multiply step, a
//   modular reduction step and a memory write step of the generator.
// Reset clears the string state and loads the generator and the registers with their defaults;
// the key memory holds no defined contents until a key has been generated.
// A finished word sits in the output register while rsp_ready is low; the block can take one
// more request and work on it, then holds its result until the output register frees.
module xor_string_cipher_prng_key_top
   import xscp_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int IW = $clog2(MAX_KEY_BYTES + 1);
   localparam int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [8:0] MAX9 = 9'(MAX_KEY_BYTES);

   state_type state_ff, state_in;

   logic [31:0]   key_seed_ff;
   logic [7:0]    key_length_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_data_ff, rsp_data_in;
   rsp_word_type  res_ff, res_in;
   logic [7:0]    item_byte_ff, item_byte_in;
   logic          inside_ff, inside_in;
   logic          trans_ff, trans_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0]   gen_state_ff, gen_state_in;
   logic [30:0]   prod_lo_ff, prod_lo_in;
   logic [30:0]   prod_hi_ff, prod_hi_in;
   logic [IW-1:0] gen_idx_ff, gen_idx_in;
   logic [31:0]   div_dvd_ff, div_dvd_in;
   logic [IW-1:0] div_rem_ff, div_rem_in;
   logic [4:0]    div_cnt_ff, div_cnt_in;

   logic [7:0]    key_mem [MAX_KEY_BYTES];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [7:0]    key_byte;

   logic [8:0]    eff9;
   logic [IW-1:0] eff_len;
   logic          out_free;
   logic          acc;
   logic          is_gen;
   logic          first;
   logic          is_term;
   logic          trans_new;
   logic          trans_use;
   logic          idx_lt;
   logic          idx_eq;
   logic          gen_last;
   logic          div_done;
   logic [IW:0]   div_trial;
   logic [IW-1:0] div_rem_next;
   logic [32:0]   gen_sum;
   logic [32:0]   gen_red;
   state_type     route;

   // Key length 0 acts as 1, and lengths above the table size saturate.
   always_comb begin
      if (key_length_ff == 8'd0) begin
         eff9 = 9'd1;
      end else if ({1'b0, key_length_ff} > MAX9) begin
         eff9 = MAX9;
      end else begin
         eff9 = {1'b0, key_length_ff};
      end
   end
   assign eff_len = eff9[IW-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_OUT) && out_free);
   assign acc       = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_gen    = (req_data.req_type == REQ_GEN_KEY);
   assign first     = !inside_ff;
   assign is_term   = (req_data.data_byte == 8'd0);
   assign trans_new = (req_data.encrypt != req_data.data_byte[7]);
   assign trans_use = first ? trans_new : trans_ff;
   assign idx_lt    = (idx_ff < eff_len);
   assign idx_eq    = (idx_ff == eff_len);
   assign gen_last  = (gen_idx_ff == (eff_len - IW'(1)));
   assign div_done  = (div_cnt_ff == 5'd0);
   assign key_byte  = key_byte_of(gen_state_ff);

   assign div_trial    = {div_rem_ff, div_dvd_ff[31]};
   assign div_rem_next = (div_trial >= {1'b0, eff_len}) ? IW'(div_trial - {1'b0, eff_len})
                                                         : IW'(div_trial);

   // Park-Miller step: fold the high product back in, then one conditional subtract.
   assign gen_sum = {2'b00, prod_lo_ff} + {2'b00, prod_hi_ff[14:0], 16'h0000}
                    + {17'h0, prod_hi_ff[30:15]};
   assign gen_red = (gen_sum > {1'b0, PM_MOD}) ? (gen_sum - {1'b0, PM_MOD}) : gen_sum;

   // Where an accepted request goes first.
   always_comb begin
      if (is_gen) begin
         route = ST_GEN_MUL;
      end else if (is_term || !trans_use) begin
         route = ST_OUT;
      end else if (first) begin
         route = ST_DIV;
      end else if (idx_lt || idx_eq) begin
         route = ST_XOR;
      end else begin
         route = ST_DIV;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               state_in = route;
            end
         end
         ST_OUT: begin
            if (acc) begin
               state_in = route;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_XOR;
            end
         end
         ST_XOR: begin
            state_in = ST_OUT;
         end
         ST_GEN_MUL: begin
            state_in = ST_GEN_ADD;
         end
         ST_GEN_ADD: begin
            state_in = ST_GEN_WR;
         end
         ST_GEN_WR: begin
            state_in = gen_last ? ST_OUT : ST_GEN_MUL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      item_byte_in = item_byte_ff;
      inside_in    = inside_ff;
      trans_in     = trans_ff;
      idx_in       = idx_ff;
      gen_state_in = gen_state_ff;
      prod_lo_in   = prod_lo_ff;
      prod_hi_in   = prod_hi_ff;
      gen_idx_in   = gen_idx_ff;
      div_dvd_in   = div_dvd_ff;
      div_rem_in   = div_rem_ff;
      div_cnt_in   = div_cnt_ff;
      rd_addr      = idx_ff[AW-1:0];
      mem_we       = 1'b0;

      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end

      if (acc) begin
         item_byte_in = req_data.data_byte;
         if (is_gen) begin
            if (key_seed_ff != 32'd0) begin
               gen_state_in = key_seed_ff;
            end
            gen_idx_in = '0;
         end else begin
            if (first) begin
               trans_in = trans_new;
            end
            if (is_term) begin
               inside_in = 1'b0;
               res_in    = '{out_byte: 8'd0, end_of_string: 1'b1, key_ready: 1'b0};
            end else begin
               inside_in = 1'b1;
               res_in    = '{out_byte: req_data.data_byte, end_of_string: 1'b0,
                             key_ready: 1'b0};
               if (trans_use) begin
                  if (first) begin
                     div_dvd_in = req_data.string_address;
                     div_rem_in = '0;
                     div_cnt_in = 5'd31;
                  end else if (idx_eq) begin
                     // Index ran off the end on the previous byte: wrap to the start.
                     idx_in  = '0;
                     rd_addr = '0;
                  end else if (!idx_lt) begin
                     div_dvd_in = 32'(idx_ff);
                     div_rem_in = '0;
                     div_cnt_in = 5'd31;
                  end
               end
            end
         end
      end

      case (state_ff)
         ST_DIV: begin
            div_dvd_in = {div_dvd_ff[30:0], 1'b0};
            div_rem_in = div_rem_next;
            div_cnt_in = div_cnt_ff - 5'd1;
            if (div_done) begin
               idx_in  = div_rem_next;
               rd_addr = div_rem_next[AW-1:0];
            end
         end
         ST_XOR: begin
            res_in = '{out_byte: item_byte_ff ^ rd_data_ff, end_of_string: 1'b0,
                       key_ready: 1'b0};
            idx_in = idx_ff + IW'(1);
         end
         ST_GEN_MUL: begin
            prod_lo_in = 31'(31'(PM_MULT) * 31'(gen_state_ff[15:0]));
            prod_hi_in = 31'(31'(PM_MULT) * 31'(gen_state_ff[31:16]));
         end
         ST_GEN_ADD: begin
            gen_state_in = gen_red[31:0];
         end
         ST_GEN_WR: begin
            mem_we     = 1'b1;
            gen_idx_in = gen_idx_ff + IW'(1);
            if (gen_last) begin
               res_in = '{out_byte: 8'd0, end_of_string: 1'b0, key_ready: 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         inside_ff     <= 1'b0;
         trans_ff      <= 1'b0;
         idx_ff        <= '0;
         gen_state_ff  <= GEN_RESET;
         key_seed_ff   <= SEED_RESET;
         key_length_ff <= LENGTH_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         inside_ff    <= inside_in;
         trans_ff     <= trans_in;
         idx_ff       <= idx_in;
         gen_state_ff <= gen_state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_SEED:   key_seed_ff   <= csr_data;
               CSR_KEY_LENGTH: key_length_ff <= csr_data[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      res_ff       <= res_in;
      item_byte_ff <= item_byte_in;
      prod_lo_ff   <= prod_lo_in;
      prod_hi_ff   <= prod_hi_in;
      gen_idx_ff   <= gen_idx_in;
      div_dvd_ff   <= div_dvd_in;
      div_rem_ff   <= div_rem_in;
      div_cnt_ff   <= div_cnt_in;
   end

   // Key table: one write port for the generator, one registered read port for the XOR path.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[gen_idx_ff[AW-1:0]] <= key_byte;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   a_div_to_xor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done) |=> (state_ff == ST_XOR))
      else $error("remainder unit did not hand over to the XOR step");

   a_gen_start: assert property (@(posedge clock) disable iff (reset)
      (acc && is_gen) |=> (state_ff == ST_GEN_MUL))
      else $error("key generation request did not start the generator");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response word loaded outside the output state");

   a_term_ends: assert property (@(posedge clock) disable iff (reset)
      (acc && !is_gen && is_term) |=> !inside_ff)
      else $error("terminator did not close the string");

endmodule
